FILE: design/thr_pkg.sv
// Package: shared types, constants and helpers of the TCP handshake responder.
package thr_pkg;

    localparam int MAX_FRAME = 1514;
    localparam int MIN_FRAME = 54;
    localparam int REPLY_LEN = 60;
    localparam int QDEPTH    = 4;
    localparam int QADDR_W   = $clog2(QDEPTH);

    localparam logic [15:0] ETH_IPV4    = 16'd2048;
    localparam logic [7:0]  IP_VER_IHL  = 8'd69;
    localparam logic [15:0] FRAG_BITS   = 16'd16383;
    localparam logic [15:0] DONT_FRAG   = 16'd16384;
    localparam logic [7:0]  TCP_HDR_OFF = 8'd80;
    localparam logic [15:0] ONES        = 16'd65535;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;

    localparam logic [7:0] FL_SYN     = 8'h02;
    localparam logic [7:0] FL_ACK     = 8'h10;
    localparam logic [7:0] FL_FIN_ACK = 8'h11;
    localparam logic [7:0] FL_PSH_ACK = 8'h18;
    localparam logic [7:0] FL_SYN_ACK = 8'h12;

    localparam logic [2:0] REG_MAC  = 3'd0;
    localparam logic [2:0] REG_IP   = 3'd1;
    localparam logic [2:0] REG_PORT = 3'd2;
    localparam logic [2:0] REG_ISN  = 3'd3;
    localparam logic [2:0] REG_WIN  = 3'd4;
    localparam logic [2:0] REG_TTL  = 3'd5;

    typedef enum logic [1:0] {
        CONN_LISTEN = 2'd0,
        CONN_SYN_RCVD = 2'd1,
        CONN_ESTAB = 2'd2,
        CONN_CLOSED = 2'd3
    } conn_state_t;

    // reply generator phases
    typedef enum logic [1:0] {
        GEN_IDLE = 2'd0,
        GEN_SUM  = 2'd1,
        GEN_SEND = 2'd2
    } gen_state_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] isn;
        logic [15:0] win;
        logic [7:0]  ttl;
    } cfg_t;

    // one reply job handed from parser to reply generator
    typedef struct packed {
        logic [47:0] dst_mac;
        logic [31:0] dst_ip;
        logic [15:0] dst_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic        done;
    } job_t;

    // ones-complement 16-bit add with end-around carry
    function automatic logic [15:0] sum16(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        begin
            t = {1'b0, s} + {1'b0, w};
            sum16 = t[15:0] + {15'd0, t[16]};
        end
    endfunction

endpackage

FILE: design/tcp_handshake_responder.sv
// Top level of the TCP handshake responder: config registers, parser, queue, reply generator.
//
// channel   dir  beat contents
// s_axis    in   tdata[7:0] rx_byte, tlast rx_last
// m_axis    out  tdata[7:0] tx_byte, tlast tx_last, tuser session_done
// apb       in   6 registers at 8*i, 64-bit data
//
// Frame bytes are taken one per cycle while the reply queue is not full; the parser keeps up byte by byte.
// A reply is built in steps: job load, checksum, then 60 output beats.
// Up to four reply jobs queue between parser and generator; s_axis_tready
// drops only when that queue is full. Output stalls hold the current byte.
// Reset (rst_n low, asynchronous) returns to listen with default registers.
module tcp_handshake_responder
    import thr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] session_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cfg_t cfg_reg;
    logic [2:0] ridx;
    logic job_push, q_pop, q_empty, q_full;
    job_t job_in, job_out;

    assign pready = 1'b1;
    assign ridx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mac: 48'd2199023255554, ip: 32'd167772162, port: 16'd49153,
                         isn: 32'd1095650113, win: 16'd4096, ttl: 8'd64};
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                REG_MAC:  cfg_reg.mac  <= pwdata[47:0];
                REG_IP:   cfg_reg.ip   <= pwdata[31:0];
                REG_PORT: cfg_reg.port <= pwdata[15:0];
                REG_ISN:  cfg_reg.isn  <= pwdata[31:0];
                REG_WIN:  cfg_reg.win  <= pwdata[15:0];
                REG_TTL:  cfg_reg.ttl  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_MAC:  prdata = {16'd0, cfg_reg.mac};
            REG_IP:   prdata = {32'd0, cfg_reg.ip};
            REG_PORT: prdata = {48'd0, cfg_reg.port};
            REG_ISN:  prdata = {32'd0, cfg_reg.isn};
            REG_WIN:  prdata = {48'd0, cfg_reg.win};
            REG_TTL:  prdata = {56'd0, cfg_reg.ttl};
            default:  prdata = '0;
        endcase
    end

    thr_parser u_parser (
        .clk, .rst_n, .cfg(cfg_reg),
        .in_valid(s_axis_tvalid), .in_byte(s_axis_tdata), .in_last(s_axis_tlast),
        .q_full, .in_ready(s_axis_tready), .job_push, .job(job_in)
    );

    thr_job_fifo u_fifo (
        .clk, .rst_n, .push(job_push), .wdata(job_in), .pop(q_pop),
        .empty(q_empty), .full(q_full), .rdata(job_out)
    );

    thr_reply_gen u_gen (
        .clk, .rst_n, .cfg(cfg_reg), .q_empty, .q_job(job_out), .q_pop,
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_byte(m_axis_tdata),
        .out_last(m_axis_tlast), .out_done(m_axis_tuser)
    );

endmodule

FILE: design/thr_parser.sv
// Front part: byte-wise parser, checksum checker and connection machine.
module thr_parser
    import thr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        q_full,
    output logic        in_ready,
    output logic        job_push,
    output job_t        job
);

    logic [10:0] idx_reg;
    logic [47:0] mac_reg;
    logic [31:0] sip_reg, seq_reg, ack_reg;
    logic [15:0] sport_reg, tlen_reg;
    logic [7:0]  flags_reg, hold_reg;
    logic [15:0] ipsum_reg, tcpsum_reg;
    logic        good_reg;
    conn_state_t state_reg, state_next;
    logic [31:0] pip_reg, rcv_reg, snd_reg, rcv_next, snd_next, pip_next;
    logic [15:0] pport_reg, pport_next;

    logic        acc;
    logic [15:0] w;
    logic        odd;
    logic [11:0] cnt;
    logic [11:0] seg_end;
    logic        good_now;
    logic [15:0] tsum;
    logic [15:0] plen;
    logic        valid_frame, match, peer_ok;
    logic [31:0] bsel;
    logic        take_syn, take_ack, take_fin, take_data;

    assign in_ready = !q_full;
    assign acc = in_valid && in_ready;
    assign w   = {hold_reg, in_byte};
    assign odd = idx_reg[0];
    assign cnt = {1'b0, idx_reg} + 12'd1;
    assign seg_end = 12'd14 + {1'b0, tlen_reg[10:0]} + {tlen_reg[15:11] != 5'd0, 11'd0};
    assign bsel = cfg.ip >> (8 * (33 - int'(idx_reg)));

    always_comb
    begin
        good_now = good_reg;
        if (cnt > 12'(MAX_FRAME)) good_now = 1'b0;
        case (idx_reg)
            11'd13: if (w != ETH_IPV4) good_now = 1'b0;
            11'd14: if (in_byte != IP_VER_IHL) good_now = 1'b0;
            11'd17: if (w < 16'd40) good_now = 1'b0;
            11'd21: if ((w & FRAG_BITS) != 16'd0) good_now = 1'b0;
            11'd23: if (in_byte != PROTO_TCP) good_now = 1'b0;
            11'd30, 11'd31, 11'd32, 11'd33: if (bsel[7:0] != in_byte) good_now = 1'b0;
            11'd37: if (w != cfg.port) good_now = 1'b0;
            11'd46: if (in_byte != TCP_HDR_OFF) good_now = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0; hold_reg <= '0; ipsum_reg <= '0; tcpsum_reg <= '0;
            good_reg <= 1'b1; mac_reg <= '0; sip_reg <= '0; seq_reg <= '0;
            ack_reg <= '0; sport_reg <= '0; tlen_reg <= '0; flags_reg <= '0;
        end
        else if (acc)
        begin
            if (idx_reg inside {[11'd6:11'd11]}) mac_reg <= {mac_reg[39:0], in_byte};
            if (idx_reg == 11'd17) tlen_reg <= w;
            if (idx_reg inside {[11'd26:11'd29]}) sip_reg <= {sip_reg[23:0], in_byte};
            if (idx_reg == 11'd35) sport_reg <= w;
            if (idx_reg inside {[11'd38:11'd41]}) seq_reg <= {seq_reg[23:0], in_byte};
            if (idx_reg inside {[11'd42:11'd45]}) ack_reg <= {ack_reg[23:0], in_byte};
            if (idx_reg == 11'd47) flags_reg <= in_byte;
            if (in_last)
            begin
                idx_reg <= '0; hold_reg <= '0; ipsum_reg <= '0; tcpsum_reg <= '0;
                good_reg <= 1'b1;
            end
            else
            begin
                good_reg <= good_now;
                if (odd && (idx_reg inside {[11'd15:11'd33]}))
                    ipsum_reg <= sum16(ipsum_reg, w);
                if (idx_reg >= 11'd26 && {1'b0, idx_reg} < seg_end)
                begin
                    if (odd) tcpsum_reg <= sum16(tcpsum_reg, w);
                    else if (cnt == seg_end) tcpsum_reg <= sum16(tcpsum_reg, {in_byte, 8'd0});
                end
                if (!odd) hold_reg <= in_byte;
                idx_reg <= (idx_reg != 11'd2047) ? idx_reg + 11'd1 : idx_reg;
            end
        end
    end

    // final byte: its own checksum contribution folded in here
    logic [15:0] ipsum_f, tcpsum_f;
    always_comb
    begin
        ipsum_f = ipsum_reg;
        tcpsum_f = tcpsum_reg;
        if (odd && (idx_reg inside {[11'd15:11'd33]})) ipsum_f = sum16(ipsum_reg, w);
        if (idx_reg >= 11'd26 && {1'b0, idx_reg} < seg_end)
        begin
            if (odd) tcpsum_f = sum16(tcpsum_reg, w);
            else if (cnt == seg_end) tcpsum_f = sum16(tcpsum_reg, {in_byte, 8'd0});
        end
        tsum = sum16(sum16(tcpsum_f, {8'd0, PROTO_TCP}), tlen_reg - 16'd20);
        plen = tlen_reg - 16'd40;
        valid_frame = good_now && cnt >= 12'(MIN_FRAME)
                      && (cnt - 12'd14) >= (seg_end - 12'd14)
                      && ipsum_f == ONES && tsum == ONES;
        peer_ok = sip_reg == pip_reg && sport_reg == pport_reg;
        match = seq_reg == rcv_reg && ack_reg == snd_reg;
    end

    // segment decode on the final byte
    // last-byte fields that are still in flight do not matter: frames are >= 54 bytes
    always_comb
    begin
        take_syn = 1'b0; take_ack = 1'b0; take_fin = 1'b0; take_data = 1'b0;
        if (acc && in_last && valid_frame)
        begin
            case (state_reg)
                CONN_LISTEN:
                    take_syn = flags_reg == FL_SYN && plen == 16'd0;
                CONN_SYN_RCVD:
                    take_ack = peer_ok && flags_reg == FL_ACK && plen == 16'd0 && match;
                CONN_ESTAB:
                begin
                    take_fin  = peer_ok && flags_reg == FL_FIN_ACK && plen == 16'd0 && match;
                    take_data = peer_ok && (flags_reg inside {FL_ACK, FL_PSH_ACK})
                                && plen != 16'd0 && match;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CONN_LISTEN:   if (take_syn) state_next = CONN_SYN_RCVD;
            CONN_SYN_RCVD: if (take_ack) state_next = CONN_ESTAB;
            CONN_ESTAB:    if (take_fin) state_next = CONN_CLOSED;
            default: ;
        endcase
    end

    always_comb
    begin
        pip_next = pip_reg; pport_next = pport_reg;
        rcv_next = rcv_reg; snd_next = snd_reg;
        job_push = take_syn || take_fin || take_data;
        job = '{dst_mac: mac_reg, dst_ip: sip_reg, dst_port: sport_reg,
                seq: snd_reg, ack: rcv_reg, flags: FL_ACK, done: 1'b0};
        if (take_syn)
        begin
            pip_next = sip_reg; pport_next = sport_reg;
            rcv_next = seq_reg + 32'd1;
            snd_next = cfg.isn + 32'd1;
            job.seq = cfg.isn; job.ack = seq_reg + 32'd1; job.flags = FL_SYN_ACK;
        end
        if (take_fin)
        begin
            rcv_next = rcv_reg + 32'd1;
            job.ack = rcv_reg + 32'd1; job.done = 1'b1;
        end
        if (take_data)
        begin
            rcv_next = rcv_reg + {16'd0, plen};
            job.ack = rcv_reg + {16'd0, plen};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CONN_LISTEN; pip_reg <= '0; pport_reg <= '0;
            rcv_reg <= '0; snd_reg <= '0;
        end
        else
        begin
            state_reg <= state_next; pip_reg <= pip_next; pport_reg <= pport_next;
            rcv_reg <= rcv_next; snd_reg <= snd_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> acc && in_last)
        else $error("reply job without a final byte");
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !q_full)
        else $error("job pushed into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CONN_CLOSED |=> state_reg == CONN_CLOSED)
        else $error("left closed state");

endmodule

FILE: design/thr_job_fifo.sv
// Short queue of reply jobs between parser and reply generator.
module thr_job_fifo
    import thr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wdata,
    input  logic pop,
    output logic empty,
    output logic full,
    output job_t rdata
);

    job_t               mem_reg [QDEPTH];
    logic [QADDR_W-1:0] wp_reg, rp_reg;
    logic [QADDR_W:0]   cnt_reg;

    assign empty = cnt_reg == '0;
    assign full  = cnt_reg == (QADDR_W + 1)'(QDEPTH);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + QADDR_W'(1);
            if (pop) rp_reg <= rp_reg + QADDR_W'(1);
            cnt_reg <= cnt_reg + {QADDR_W'(0), push} - {QADDR_W'(0), pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= (QADDR_W + 1)'(QDEPTH))
        else $error("queue count overflow");

endmodule

FILE: design/thr_reply_gen.sv
// Back part: builds the 60-byte reply frame and streams it out.
module thr_reply_gen
    import thr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_empty,
    input  job_t        q_job,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        out_done
);

    job_t        job_reg;
    gen_state_t  state_reg, state_next;
    logic [5:0]  pos_reg;
    logic [15:0] ipck_reg, tcpck_reg;
    logic [16:0] ip_s, tcp_s;

    // checksums from wide sums folded twice; one combinational add tree each
    always_comb
    begin
        logic [19:0] a, b;
        a = 20'h4500 + 20'd40 + {4'd0, DONT_FRAG} + {4'd0, cfg.ttl, PROTO_TCP}
            + {4'd0, cfg.ip[31:16]} + {4'd0, cfg.ip[15:0]}
            + {4'd0, job_reg.dst_ip[31:16]} + {4'd0, job_reg.dst_ip[15:0]};
        b = {12'd0, PROTO_TCP} + 20'd20
            + {4'd0, cfg.ip[31:16]} + {4'd0, cfg.ip[15:0]}
            + {4'd0, job_reg.dst_ip[31:16]} + {4'd0, job_reg.dst_ip[15:0]}
            + {4'd0, cfg.port} + {4'd0, job_reg.dst_port}
            + {4'd0, job_reg.seq[31:16]} + {4'd0, job_reg.seq[15:0]}
            + {4'd0, job_reg.ack[31:16]} + {4'd0, job_reg.ack[15:0]}
            + {4'd0, TCP_HDR_OFF, job_reg.flags} + {4'd0, cfg.win};
        ip_s  = {1'b0, a[15:0]} + {13'd0, a[19:16]};
        tcp_s = {1'b0, b[15:0]} + {13'd0, b[19:16]};
    end

    // idle -> sum (job loaded) -> send 60 beats -> idle
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            GEN_IDLE: if (!q_empty) state_next = GEN_SUM;
            GEN_SUM:  state_next = GEN_SEND;
            GEN_SEND: if (out_ready && out_last) state_next = GEN_IDLE;
            default:  state_next = GEN_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            GEN_IDLE: q_pop = !q_empty;
            GEN_SEND: out_valid = 1'b1;
            default: ;
        endcase
    end

    assign out_last = pos_reg == 6'(REPLY_LEN - 1);
    assign out_done = job_reg.done;

    always_comb
    begin
        case (pos_reg)
            6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5:
                out_byte = 8'(job_reg.dst_mac >> (8 * (5 - int'(pos_reg))));
            6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11:
                out_byte = 8'(cfg.mac >> (8 * (11 - int'(pos_reg))));
            6'd12: out_byte = ETH_IPV4[15:8];
            6'd13: out_byte = ETH_IPV4[7:0];
            6'd14: out_byte = IP_VER_IHL;
            6'd17: out_byte = 8'd40;
            6'd20: out_byte = DONT_FRAG[15:8];
            6'd22: out_byte = cfg.ttl;
            6'd23: out_byte = PROTO_TCP;
            6'd24: out_byte = ipck_reg[15:8];
            6'd25: out_byte = ipck_reg[7:0];
            6'd26, 6'd27, 6'd28, 6'd29:
                out_byte = 8'(cfg.ip >> (8 * (29 - int'(pos_reg))));
            6'd30, 6'd31, 6'd32, 6'd33:
                out_byte = 8'(job_reg.dst_ip >> (8 * (33 - int'(pos_reg))));
            6'd34: out_byte = cfg.port[15:8];
            6'd35: out_byte = cfg.port[7:0];
            6'd36: out_byte = job_reg.dst_port[15:8];
            6'd37: out_byte = job_reg.dst_port[7:0];
            6'd38, 6'd39, 6'd40, 6'd41:
                out_byte = 8'(job_reg.seq >> (8 * (41 - int'(pos_reg))));
            6'd42, 6'd43, 6'd44, 6'd45:
                out_byte = 8'(job_reg.ack >> (8 * (45 - int'(pos_reg))));
            6'd46: out_byte = TCP_HDR_OFF;
            6'd47: out_byte = job_reg.flags;
            6'd48: out_byte = cfg.win[15:8];
            6'd49: out_byte = cfg.win[7:0];
            6'd50: out_byte = tcpck_reg[15:8];
            6'd51: out_byte = tcpck_reg[7:0];
            default: out_byte = 8'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) job_reg <= q_job;
        if (state_reg == GEN_SUM)
        begin
            ipck_reg  <= ONES - (ip_s[15:0] + {15'd0, ip_s[16]});
            tcpck_reg <= ONES - (tcp_s[15:0] + {15'd0, tcp_s[16]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= GEN_IDLE; pos_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop) pos_reg <= '0;
            else if (out_valid && out_ready) pos_reg <= pos_reg + 6'd1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) state_reg == GEN_SUM |=> out_valid)
        else $error("checksum phase not followed by streaming");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid)
        else $error("stream continued after last byte");
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> pos_reg < 6'(REPLY_LEN))
        else $error("byte position out of range");

endmodule

FILE: tb/tcp_handshake_responder_tb.sv
// Testbench for the TCP handshake responder: frame stimulus, reply prediction and checking.
`timescale 1ns / 100ps

module tcp_handshake_responder_tb;
    import thr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 100;

    // frame damage kinds used to build rejected frames
    typedef enum int {
        DMG_NONE, DMG_ETYPE, DMG_VER, DMG_LEN_SHORT, DMG_IP_SUM, DMG_FRAG, DMG_PROTO,
        DMG_DST_IP, DMG_TCP_OFF, DMG_TCP_SUM, DMG_DST_PORT, DMG_TRUNC, DMG_LEN_LONG
    } damage_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       done;
    } reply_beat_t;

    // Tracks the responder state beat by beat and holds the reply bytes still owed.
    class reply_scoreboard;
        logic [47:0] local_mac;
        logic [31:0] local_ip;
        logic [15:0] local_port;
        logic [31:0] initial_seq;
        logic [15:0] window_size;
        logic [7:0]  ttl;

        conn_state_t conn;
        logic [31:0] peer_ip, rcv_next, snd_next;
        logic [15:0] peer_port;
        int          byte_index;
        logic [47:0] src_mac;
        logic [31:0] src_ip, seg_seq, seg_ack;
        logic [15:0] src_port, total_len, ip_acc, tcp_acc;
        logic [7:0]  seg_flags, hold;
        bit          good;

        reply_beat_t owed[$];
        int          errors;

        function new();
            local_mac = 48'd2199023255554;
            local_ip = 32'd167772162;
            local_port = 16'd49153;
            initial_seq = 32'd1095650113;
            window_size = 16'd4096;
            ttl = 8'd64;
            conn = CONN_LISTEN;
            peer_ip = 0; peer_port = 0; rcv_next = 0; snd_next = 0;
            src_mac = 0; src_ip = 0; src_port = 0; seg_seq = 0; seg_ack = 0;
            seg_flags = 0; total_len = 0;
            errors = 0;
            clear_frame();
        endfunction

        static function logic [15:0] ones_add(logic [15:0] s, logic [15:0] w);
            logic [16:0] t;
            t = {1'b0, s} + {1'b0, w};
            return t[15:0] + {15'd0, t[16]};
        endfunction

        function void clear_frame();
            byte_index = 0;
            ip_acc = 0;
            tcp_acc = 0;
            hold = 0;
            good = 1;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                REG_MAC:  local_mac = val[47:0];
                REG_IP:   local_ip = val[31:0];
                REG_PORT: local_port = val[15:0];
                REG_ISN:  initial_seq = val[31:0];
                REG_WIN:  window_size = val[15:0];
                REG_TTL:  ttl = val[7:0];
                default: ;
            endcase
        endfunction

        function void queue_reply(logic [7:0] flags, logic [31:0] seq, logic [31:0] ack,
                                  logic done);
            logic [7:0]  f[REPLY_LEN];
            logic [15:0] s;
            reply_beat_t rb;
            foreach (f[k]) f[k] = 8'h00;
            for (int k = 0; k < 6; k++) begin
                f[k] = src_mac[8*(5-k) +: 8];
                f[6+k] = local_mac[8*(5-k) +: 8];
            end
            {f[12], f[13]} = ETH_IPV4;
            f[14] = IP_VER_IHL;
            {f[16], f[17]} = 16'd40;
            {f[20], f[21]} = DONT_FRAG;
            f[22] = ttl;
            f[23] = PROTO_TCP;
            {f[26], f[27], f[28], f[29]} = local_ip;
            {f[30], f[31], f[32], f[33]} = src_ip;
            {f[34], f[35]} = local_port;
            {f[36], f[37]} = src_port;
            {f[38], f[39], f[40], f[41]} = seq;
            {f[42], f[43], f[44], f[45]} = ack;
            f[46] = TCP_HDR_OFF;
            f[47] = flags;
            {f[48], f[49]} = window_size;
            // pseudo header: addresses come from the header bytes themselves
            s = ones_add(16'd0, {8'd0, PROTO_TCP});
            s = ones_add(s, 16'd20);
            for (int k = 26; k < 54; k += 2) s = ones_add(s, {f[k], f[k+1]});
            {f[50], f[51]} = ~s;
            s = 0;
            for (int k = 14; k < 34; k += 2) s = ones_add(s, {f[k], f[k+1]});
            {f[24], f[25]} = ~s;
            for (int k = 0; k < REPLY_LEN; k++) begin
                rb.data = f[k];
                rb.last = (k == REPLY_LEN - 1);
                rb.done = done;
                owed.push_back(rb);
            end
        endfunction

        function void end_of_frame(int cnt);
            logic [31:0] plen;
            logic [15:0] t;
            bit          in_sync;
            if (!good || cnt < MIN_FRAME || cnt - 14 < int'(total_len)) return;
            if (ip_acc != ONES) return;
            t = ones_add(ones_add(tcp_acc, {8'd0, PROTO_TCP}), total_len - 16'd20);
            if (t != ONES) return;
            plen = {16'd0, total_len} - 32'd40;
            if (conn == CONN_LISTEN) begin
                if (seg_flags == FL_SYN && plen == 0) begin
                    peer_ip = src_ip;
                    peer_port = src_port;
                    rcv_next = seg_seq + 1;
                    snd_next = initial_seq + 1;
                    conn = CONN_SYN_RCVD;
                    queue_reply(FL_SYN_ACK, initial_seq, rcv_next, 1'b0);
                end
                return;
            end
            if (src_ip != peer_ip || src_port != peer_port) return;
            in_sync = (seg_seq == rcv_next) && (seg_ack == snd_next);
            if (conn == CONN_SYN_RCVD) begin
                if (seg_flags == FL_ACK && plen == 0 && in_sync) conn = CONN_ESTAB;
            end else if (conn == CONN_ESTAB) begin
                if (seg_flags == FL_FIN_ACK) begin
                    if (plen == 0 && in_sync) begin
                        rcv_next = rcv_next + 1;
                        conn = CONN_CLOSED;
                        queue_reply(FL_ACK, snd_next, rcv_next, 1'b1);
                    end
                end else if ((seg_flags == FL_ACK || seg_flags == FL_PSH_ACK) && plen > 0
                             && in_sync) begin
                    rcv_next = rcv_next + plen;
                    queue_reply(FL_ACK, snd_next, rcv_next, 1'b0);
                end
            end
        endfunction

        // one accepted input beat
        function void note_rx(logic [7:0] b, logic last);
            int          pos;
            logic [15:0] w;
            pos = byte_index;
            w = {hold, b};
            if (pos + 1 > MAX_FRAME) good = 0;
            if (pos >= 6 && pos <= 11) src_mac = {src_mac[39:0], b};
            else if (pos == 13 && w != ETH_IPV4) good = 0;
            else if (pos == 14 && b != IP_VER_IHL) good = 0;
            else if (pos == 17) begin
                total_len = w;
                if (w < 16'd40) good = 0;
            end
            else if (pos == 21 && (w & FRAG_BITS) != 0) good = 0;
            else if (pos == 23 && b != PROTO_TCP) good = 0;
            else if (pos >= 26 && pos <= 29) src_ip = {src_ip[23:0], b};
            else if (pos >= 30 && pos <= 33) begin
                if (local_ip[8*(33-pos) +: 8] != b) good = 0;
            end
            else if (pos == 35) src_port = w;
            else if (pos == 37 && w != local_port) good = 0;
            else if (pos >= 38 && pos <= 41) seg_seq = {seg_seq[23:0], b};
            else if (pos >= 42 && pos <= 45) seg_ack = {seg_ack[23:0], b};
            else if (pos == 46 && b != TCP_HDR_OFF) good = 0;
            else if (pos == 47) seg_flags = b;

            if (pos[0] && pos >= 15 && pos <= 33) ip_acc = ones_add(ip_acc, w);
            if (pos >= 26 && pos < 14 + int'(total_len)) begin
                if (pos[0]) tcp_acc = ones_add(tcp_acc, w);
                else if (pos + 1 == 14 + int'(total_len)) tcp_acc = ones_add(tcp_acc, {b, 8'h00});
            end
            if (!pos[0]) hold = b;
            byte_index = (pos < 2047) ? pos + 1 : 2047;
            if (last) begin
                end_of_frame(pos + 1);
                clear_frame();
            end
        endfunction

        // one accepted output beat against the oldest owed reply byte
        function void check_tx(logic [7:0] b, logic last, logic done);
            reply_beat_t rb;
            if (owed.size() == 0) begin
                $error("unexpected reply beat: tx_byte %0h", b);
                errors++;
                return;
            end
            rb = owed.pop_front();
            if (b !== rb.data) begin
                $error("tx_byte expected %0h actual %0h", rb.data, b);
                errors++;
            end
            if (last !== rb.last) begin
                $error("tx_last expected %0b actual %0b", rb.last, last);
                errors++;
            end
            if (done !== rb.done) begin
                $error("session_done expected %0b actual %0b", rb.done, done);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] tx_byte
    logic        m_axis_tlast;
    logic        m_axis_tuser;   // [0] session_done
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    tcp_handshake_responder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    reply_scoreboard sb = new();

    logic [7:0] frm[$];         // frame under construction
    int         burst_left = 0; // sender beats left before the next gap
    bit         steady = 0;     // 1: sender offers back to back
    bit         hold_req = 0;   // asks the receiver for a long hold-off
    int         cycles = 0;

    logic [31:0] peer_ip;
    logic [15:0] peer_port;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: checks at the rising edge, picks tready at the falling edge.
    // The stall pattern switches between free flow, light and heavy stalls and
    // a periodic pattern; a hold-off request parks tready low for a long stretch.
    initial begin : receiver
        int mode;
        int mode_left;
        int hold_cnt;
        int phase;
        mode = 0;
        mode_left = 0;
        hold_cnt = 0;
        phase = 0;
        m_axis_tready = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_tx(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            @(negedge clk);
            if (hold_req) begin
                hold_req = 0;
                hold_cnt = 2000;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            phase++;
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready = 0;
            end else begin
                case (mode)
                    0: m_axis_tready = 1;
                    1: m_axis_tready = ($urandom_range(0, 3) != 0);
                    2: m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = (phase % 5 < 2);
                endcase
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = {idx, 3'b000};
        pwdata = val;
        @(negedge clk);
        penable = 1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic write_all(logic [47:0] mac, logic [31:0] ip, logic [15:0] port,
                             logic [31:0] isn, logic [15:0] win, logic [7:0] ttl);
        apb_write(REG_MAC, {16'd0, mac});
        apb_write(REG_IP, {32'd0, ip});
        apb_write(REG_PORT, {48'd0, port});
        apb_write(REG_ISN, {32'd0, isn});
        apb_write(REG_WIN, {48'd0, win});
        apb_write(REG_TTL, {56'd0, ttl});
    endtask

    // sender quiet, all owed replies out, then a margin for the generator to settle
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 0;
        s_axis_tlast = 0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_beat(logic [7:0] b, logic last);
        @(negedge clk);
        if (!steady && burst_left == 0) begin
            s_axis_tvalid = 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 48);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = b;
        s_axis_tlast = last;
        if (burst_left > 0) burst_left--;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_rx(b, last);
    endtask

    function automatic void put16(logic [15:0] v);
        frm.push_back(v[15:8]);
        frm.push_back(v[7:0]);
    endfunction

    function automatic void put32(logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endfunction

    // Builds a well-formed segment with both checksums right, then applies the chosen damage, if any.
    function automatic void build_segment(logic [31:0] sip, logic [15:0] sport,
            logic [31:0] seq, logic [31:0] ack, logic [7:0] flags, int plen, int pad,
            damage_t dmg);
        logic [15:0] total;
        logic [15:0] s;
        int          seg_end;
        int          cut;
        frm.delete();
        total = 16'(40 + plen);
        put32($urandom); put16(16'($urandom));
        put32($urandom); put16(16'($urandom));
        put16(ETH_IPV4);
        frm.push_back(IP_VER_IHL);
        frm.push_back(8'($urandom));
        put16(total);
        put16(16'($urandom));
        put16({$urandom_range(0, 3) == 0 ? 2'b00 : 2'(($urandom_range(0, 3))), 14'd0});
        frm.push_back(8'($urandom));
        frm.push_back(PROTO_TCP);
        put16(16'd0);
        put32(sip);
        put32(sb.local_ip);
        put16(sport);
        put16(sb.local_port);
        put32(seq);
        put32(ack);
        frm.push_back(TCP_HDR_OFF);
        frm.push_back(flags);
        put16(16'($urandom));
        put16(16'd0);
        put16(16'($urandom));
        for (int k = 0; k < plen; k++) frm.push_back(8'($urandom));
        s = 0;
        for (int k = 14; k < 34; k += 2) s = reply_scoreboard::ones_add(s, {frm[k], frm[k+1]});
        {frm[24], frm[25]} = ~s;
        seg_end = 14 + int'(total);
        s = reply_scoreboard::ones_add(16'd0, {8'd0, PROTO_TCP});
        s = reply_scoreboard::ones_add(s, total - 16'd20);
        for (int k = 26; k < seg_end; k += 2)
            s = reply_scoreboard::ones_add(s, {frm[k], (k + 1 < seg_end) ? frm[k+1] : 8'h00});
        {frm[50], frm[51]} = ~s;
        for (int k = 0; k < pad; k++) frm.push_back(8'($urandom));
        case (dmg)
            DMG_ETYPE:     frm[12] = frm[12] ^ 8'h01;
            DMG_VER:       frm[14] = 8'h46;
            DMG_LEN_SHORT: {frm[16], frm[17]} = 16'd39;
            DMG_IP_SUM:    frm[24] = frm[24] ^ 8'h80;
            DMG_FRAG:      frm[21] = frm[21] | 8'h01;
            DMG_PROTO:     frm[23] = 8'd17;
            DMG_DST_IP:    frm[33] = frm[33] ^ 8'h01;
            DMG_TCP_OFF:   frm[46] = 8'h60;
            DMG_TCP_SUM:   frm[51] = frm[51] ^ 8'h01;
            DMG_DST_PORT:  frm[37] = frm[37] ^ 8'h01;
            DMG_TRUNC: begin
                cut = $urandom_range(1, MIN_FRAME - 1);
                while (frm.size() > cut) void'(frm.pop_back());
            end
            DMG_LEN_LONG:  {frm[16], frm[17]} = total + 16'(pad + 2);
            default: ;
        endcase
    endfunction

    task automatic send_frame();
        for (int i = 0; i < frm.size(); i++) send_beat(frm[i], i == frm.size() - 1);
    endtask

    task automatic send_segment(logic [31:0] sip, logic [15:0] sport, logic [31:0] seq,
            logic [31:0] ack, logic [7:0] flags, int plen, int pad, damage_t dmg);
        build_segment(sip, sport, seq, ack, flags, plen, pad, dmg);
        send_frame();
    endtask

    // in-sequence segment from the peer
    task automatic send_in_seq(logic [7:0] flags, int plen, int pad);
        send_segment(peer_ip, peer_port, sb.rcv_next, sb.snd_next, flags, plen, pad, DMG_NONE);
    endtask

    // raw byte soup, one frame of the given length
    task automatic send_garbage(int len);
        frm.delete();
        for (int k = 0; k < len; k++) frm.push_back(8'($urandom));
        send_frame();
    endtask

    initial begin : stimulus
        logic [31:0] peer_isn;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        peer_ip = $urandom;
        peer_port = 16'($urandom);
        peer_isn = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));

        // listen with reset registers: a broken SYN is not answered
        send_segment(peer_ip, peer_port, peer_isn, $urandom, FL_SYN, 0, 0,
                     damage_t'($urandom_range(DMG_ETYPE, DMG_LEN_LONG)));
        wait_idle();

        // random registers; an all-ones initial sequence wraps the send side
        write_all(48'({$urandom, $urandom}), $urandom, 16'($urandom), '1,
                  16'($urandom), 8'($urandom));

        // receiver holds off from the SYN-ACK on, so the replies pile up and the
        // queue fills; the frame after the FIN stalls on its first beat
        hold_req = 1;
        steady = 1;
        send_segment(peer_ip, peer_port, peer_isn, $urandom, FL_SYN, 0, 0, DMG_NONE);
        send_in_seq(FL_ACK, 0, 0);
        send_in_seq(FL_PSH_ACK, 1, 0);
        send_in_seq(FL_ACK, 2, 0);
        send_in_seq(FL_PSH_ACK, 1, 0);
        send_in_seq(FL_FIN_ACK, 0, 0);
        send_in_seq(FL_PSH_ACK, 1, 0);          // closed: ignored
        steady = 0;

        @(negedge clk);
        s_axis_tvalid = 0;
        s_axis_tlast = 0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
design/thr_pkg.sv
design/thr_parser.sv
design/thr_job_fifo.sv
design/thr_reply_gen.sv
design/tcp_handshake_responder.sv
tb/tcp_handshake_responder_tb.sv
